[rtl/projective_point_transform_top_assert.svh]
// assertion helpers for the projective point transform
`ifndef PROJECTIVE_POINT_TRANSFORM_TOP_ASSERT_SVH
`define PROJECTIVE_POINT_TRANSFORM_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define PPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also watches reset itself
`define PPT_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ppt_pkg.sv]
`default_nettype none
package ppt_pkg;

  localparam int COORD_W = 16;
  localparam int COEF_W  = 21;
  localparam int ROW_W   = 3 * COEF_W;
  localparam int LIMIT_W = 16;
  localparam int IDX_W   = 2;

  localparam int PROD_W  = COEF_W + COORD_W;      // one coefficient times one coordinate
  localparam int HOM_W   = PROD_W + 1;            // sum of three terms
  localparam int MAG_W   = HOM_W - 1;
  localparam int SQ_LO_W = 19;
  localparam int SQ_HI_W = MAG_W - SQ_LO_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int TOTAL_W = SQ_W + 2;
  localparam int T2_W    = 2 * LIMIT_W;
  localparam int CHUNK_W = 26;
  localparam int PART_W  = CHUNK_W + T2_W;
  localparam int CMP_W   = TOTAL_W + T2_W;
  localparam int NUM_W   = HOM_W + 4;             // x times 16
  localparam int QUO_W   = COORD_W;

  localparam int DOT_LAT   = 2;
  localparam int DEPTH_LAT = 5;
  localparam int DIV_LAT   = QUO_W + 3;

  localparam logic [IDX_W-1:0] REG_ROW_TOP     = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW_MIDDLE  = 2'd1;
  localparam logic [IDX_W-1:0] REG_ROW_BOTTOM  = 2'd2;
  localparam logic [IDX_W-1:0] REG_DEPTH_LIMIT = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] mapped_col;
    logic signed [COORD_W-1:0] mapped_row;
    logic                      ok;
  } result_t;

  typedef struct packed {
    logic signed [HOM_W-1:0] hx;
    logic signed [HOM_W-1:0] hy;
    logic signed [HOM_W-1:0] hw;
  } hom_t;

endpackage
`default_nettype wire

[rtl/ppt_dot.sv]
`default_nettype none
module ppt_dot (
  input  wire                            clk,
  input  wire                            en,
  input  ppt_pkg::point_t                point,
  input  wire  [ppt_pkg::ROW_W-1:0]      row_top,
  input  wire  [ppt_pkg::ROW_W-1:0]      row_middle,
  input  wire  [ppt_pkg::ROW_W-1:0]      row_bottom,
  output ppt_pkg::hom_t                  hom
);

  localparam int CW = ppt_pkg::COEF_W;

  logic        [ppt_pkg::ROW_W-1:0]  rows [3];
  logic signed [ppt_pkg::PROD_W-1:0] px   [3];
  logic signed [ppt_pkg::PROD_W-1:0] py   [3];
  logic signed [CW-1:0]              pc   [3];
  logic signed [ppt_pkg::HOM_W-1:0]  hv   [3];

  assign rows[0] = row_top;
  assign rows[1] = row_middle;
  assign rows[2] = row_bottom;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        px[r] <= $signed(rows[r][CW-1:0]) * point.point_x;
        py[r] <= $signed(rows[r][2*CW-1:CW]) * point.point_y;
        pc[r] <= $signed(rows[r][3*CW-1:2*CW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        hv[r] <= ppt_pkg::HOM_W'(px[r]) + ppt_pkg::HOM_W'(py[r])
               + (ppt_pkg::HOM_W'(pc[r]) <<< 4);
      end
    end
  end

  assign hom.hx = hv[0];
  assign hom.hy = hv[1];
  assign hom.hw = hv[2];

endmodule
`default_nettype wire

[rtl/ppt_depth.sv]
`default_nettype none
module ppt_depth (
  input  wire                             clk,
  input  wire                             en,
  input  ppt_pkg::hom_t                   hom,
  input  wire  [ppt_pkg::LIMIT_W-1:0]     depth_limit,
  output logic                            pass
);

  localparam int LO = ppt_pkg::SQ_LO_W;
  localparam int HI = ppt_pkg::SQ_HI_W;
  localparam int CK = ppt_pkg::CHUNK_W;

  logic signed [ppt_pkg::HOM_W-1:0]   hv  [3];
  logic        [ppt_pkg::HOM_W-1:0]   neg [3];
  logic        [ppt_pkg::MAG_W-1:0]   mag [3];
  logic        [2*LO-1:0]             pll [3];
  logic        [HI+LO-1:0]            plh [3];
  logic        [2*HI-1:0]             phh [3];
  logic        [ppt_pkg::SQ_W-1:0]    sq  [3];
  logic        [ppt_pkg::T2_W-1:0]    t2;
  logic        [ppt_pkg::T2_W-1:0]    t2_b;
  logic        [ppt_pkg::T2_W-1:0]    t2_c;
  logic        [ppt_pkg::TOTAL_W-1:0] total;
  logic        [ppt_pkg::SQ_W-1:0]    w2;
  logic        [ppt_pkg::PART_W-1:0]  part [3];
  logic        [ppt_pkg::CMP_W-1:0]   lhs;
  logic        [ppt_pkg::CMP_W-1:0]   rhs;

  assign hv[0] = hom.hx;
  assign hv[1] = hom.hy;
  assign hv[2] = hom.hw;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg[k] = -hv[k];
      mag[k] = hv[k][ppt_pkg::HOM_W-1] ? neg[k][ppt_pkg::MAG_W-1:0]
                                       : hv[k][ppt_pkg::MAG_W-1:0];
    end
  end

  // squares from split halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pll[k] <= mag[k][LO-1:0] * mag[k][LO-1:0];
        plh[k] <= mag[k][ppt_pkg::MAG_W-1:LO] * mag[k][LO-1:0];
        phh[k] <= mag[k][ppt_pkg::MAG_W-1:LO] * mag[k][ppt_pkg::MAG_W-1:LO];
      end
      t2 <= depth_limit * depth_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] <= (ppt_pkg::SQ_W'(phh[k]) << (2 * LO))
               + (ppt_pkg::SQ_W'(plh[k]) << (LO + 1))
               + ppt_pkg::SQ_W'(pll[k]);
      end
      t2_b <= t2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total <= ppt_pkg::TOTAL_W'(sq[0]) + ppt_pkg::TOTAL_W'(sq[1])
             + ppt_pkg::TOTAL_W'(sq[2]);
      w2    <= sq[2];
      t2_c  <= t2_b;
    end
  end

  // tolerance side cut into chunk products
  always_ff @(posedge clk) begin
    if (en) begin
      part[0] <= total[CK-1:0] * t2_c;
      part[1] <= total[2*CK-1:CK] * t2_c;
      part[2] <= ppt_pkg::PART_W'(total[ppt_pkg::TOTAL_W-1:2*CK]) * t2_c;
      lhs     <= ppt_pkg::CMP_W'(w2) << ppt_pkg::T2_W;
    end
  end

  assign rhs = ppt_pkg::CMP_W'(part[0]) + (ppt_pkg::CMP_W'(part[1]) << CK)
             + (ppt_pkg::CMP_W'(part[2]) << (2 * CK));

  always_ff @(posedge clk) begin
    if (en) begin
      pass <= lhs > rhs;
    end
  end

endmodule
`default_nettype wire

[rtl/ppt_div.sv]
`default_nettype none
module ppt_div (
  input  wire                                 clk,
  input  wire                                 en,
  input  wire  signed [ppt_pkg::NUM_W-1:0]    num,
  input  wire  signed [ppt_pkg::HOM_W-1:0]    den,
  output logic signed [ppt_pkg::QUO_W-1:0]    quo
);

  localparam int NW    = ppt_pkg::NUM_W;
  localparam int DW    = ppt_pkg::HOM_W;
  localparam int QW    = ppt_pkg::QUO_W;
  localparam int REM_W = DW + QW;
  localparam logic [QW-1:0]        MIN_MAG = QW'(1) << (QW - 1);
  localparam logic [QW-1:0]        MAX_MAG = MIN_MAG - QW'(1);
  localparam logic signed [QW-1:0] SAT_MAX = $signed(MAX_MAG);
  localparam logic signed [QW-1:0] SAT_MIN = $signed(MIN_MAG);

  logic [NW-1:0] num_neg;
  logic [DW-1:0] den_neg;
  logic [NW-1:0] nmag0;
  logic [DW-1:0] dmag0;
  logic          sgn0;

  logic [NW-1:0] rem [QW+1];
  logic [DW-1:0] dm  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic          ng  [QW+1];
  logic          ov  [QW+1];

  assign num_neg = -num;
  assign den_neg = -den;

  always_ff @(posedge clk) begin
    if (en) begin
      nmag0 <= num[NW-1] ? num_neg : num;
      dmag0 <= den[DW-1] ? den_neg : den;
      sgn0  <= num[NW-1] ^ den[DW-1];
    end
  end

  // quotient too big for the 16 quotient bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= nmag0;
      dm[0]  <= dmag0;
      q[0]   <= '0;
      ng[0]  <= sgn0;
      ov[0]  <= REM_W'(nmag0) >= (REM_W'(dmag0) << QW);
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int B = QW - 1 - j;
    logic [REM_W-1:0] trial;
    assign trial = REM_W'(dm[j]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (REM_W'(rem[j]) >= trial) begin
          rem[j+1] <= rem[j] - trial[NW-1:0];
          q[j+1]   <= q[j] | (QW'(1) << B);
        end else begin
          rem[j+1] <= rem[j];
          q[j+1]   <= q[j];
        end
        dm[j+1] <= dm[j];
        ng[j+1] <= ng[j];
        ov[j+1] <= ov[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ov[QW]) begin
        quo <= ng[QW] ? SAT_MIN : SAT_MAX;
      end else if (ng[QW]) begin
        quo <= (q[QW] > MIN_MAG) ? SAT_MIN : -$signed(q[QW]);
      end else begin
        quo <= (q[QW] > MAX_MAG) ? SAT_MAX : $signed(q[QW]);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/projective_point_transform_top.sv]
// projective point transform: maps a point through a 3x3 homography
// point channel: point_valid / point_stall with point (x, y in Q12.4)
// result channel: result_valid / result_stall with result (col, row, ok)
// config channel: cfg_valid / cfg_ready, cfg_index picks row_top, row_middle,
//   row_bottom or depth_limit; cfg_ready is always high, write only when idle
// one request enters per cycle while point_stall is low
// the bulk of the pipeline is the 16-step restoring divider, one quotient bit a stage
// the depth test runs alongside and is delayed to meet the quotients
// when the receiver stalls a waiting result, the whole pipeline freezes and
//   point_stall rises in the same cycle; nothing is dropped or repeated
// reset clears all valid bits and loads the identity homography with
//   depth_limit 16; no clearing pass is needed
`default_nettype none
module projective_point_transform_top (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              point_valid,
  output logic                             point_stall,
  input  ppt_pkg::point_t                  point,
  output logic                             result_valid,
  input  wire                              result_stall,
  output ppt_pkg::result_t                 result,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [ppt_pkg::IDX_W-1:0]        cfg_index,
  input  wire  [ppt_pkg::ROW_W-1:0]        cfg_data
);

  localparam int PIPE_LAT = ppt_pkg::DOT_LAT + ppt_pkg::DIV_LAT;
  localparam int PASS_DLY = ppt_pkg::DIV_LAT - ppt_pkg::DEPTH_LAT;
  localparam logic [ppt_pkg::ROW_W-1:0] ONE = ppt_pkg::ROW_W'(1) << 16;

  logic [ppt_pkg::ROW_W-1:0]   row_top;
  logic [ppt_pkg::ROW_W-1:0]   row_middle;
  logic [ppt_pkg::ROW_W-1:0]   row_bottom;
  logic [ppt_pkg::LIMIT_W-1:0] depth_limit;

  logic                                adv;
  logic                                vld      [PIPE_LAT];
  logic                                pass;
  logic                                pass_dly [PASS_DLY];
  ppt_pkg::hom_t                       hom;
  logic signed [ppt_pkg::QUO_W-1:0]    col_q;
  logic signed [ppt_pkg::QUO_W-1:0]    row_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_top     <= ONE;
      row_middle  <= ONE << ppt_pkg::COEF_W;
      row_bottom  <= ONE << (2 * ppt_pkg::COEF_W);
      depth_limit <= ppt_pkg::LIMIT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ppt_pkg::REG_ROW_TOP:     row_top     <= cfg_data;
        ppt_pkg::REG_ROW_MIDDLE:  row_middle  <= cfg_data;
        ppt_pkg::REG_ROW_BOTTOM:  row_bottom  <= cfg_data;
        ppt_pkg::REG_DEPTH_LIMIT: depth_limit <= cfg_data[ppt_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // everything moves unless a finished result is held back
  assign adv         = !(result_valid && result_stall);
  assign point_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) vld[i] <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= point_valid;
      for (int i = 1; i < PIPE_LAT; i++) vld[i] <= vld[i-1];
      result_valid <= vld[PIPE_LAT-1];
    end
  end

  ppt_dot u_dot (
    .clk        (clk),
    .en         (adv),
    .point      (point),
    .row_top    (row_top),
    .row_middle (row_middle),
    .row_bottom (row_bottom),
    .hom        (hom)
  );

  ppt_depth u_depth (
    .clk         (clk),
    .en          (adv),
    .hom         (hom),
    .depth_limit (depth_limit),
    .pass        (pass)
  );

  ppt_div u_div_col (
    .clk (clk),
    .en  (adv),
    .num (ppt_pkg::NUM_W'(hom.hx) <<< 4),
    .den (hom.hw),
    .quo (col_q)
  );

  ppt_div u_div_row (
    .clk (clk),
    .en  (adv),
    .num (ppt_pkg::NUM_W'(hom.hy) <<< 4),
    .den (hom.hw),
    .quo (row_q)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      pass_dly[0] <= pass;
      for (int i = 1; i < PASS_DLY; i++) pass_dly[i] <= pass_dly[i-1];
    end
  end

  // rejected points, zero depth included, give zeros
  always_ff @(posedge clk) begin
    if (adv) begin
      result.ok         <= pass_dly[PASS_DLY-1];
      result.mapped_col <= pass_dly[PASS_DLY-1] ? col_q : '0;
      result.mapped_row <= pass_dly[PASS_DLY-1] ? row_q : '0;
    end
  end

`include "projective_point_transform_top_assert.svh"

  `PPT_ASSERT_SAME(a_reject_zero, result_valid && !result.ok,
    result.mapped_col == '0 && result.mapped_row == '0, "rejected point not zero")
  `PPT_ASSERT_SAME(a_freeze, result_valid && result_stall, point_stall,
    "pipeline takes a request while the result is held")
  `PPT_ASSERT_NEXT(a_enter, point_valid && !point_stall, vld[0],
    "accepted request lost at entry")
  `PPT_ASSERT_RESET(a_reset, rst, !result_valid && !vld[0],
    "valid bits not cleared by reset")

endmodule
`default_nettype wire
